// ----- hw/rtl/alv_pkg.sv -----
// ----------------------------------------------------------------------------
// alv_pkg: shared types and constants for the arc tessellator
// Arc descriptor, step count and the fixed-point sine coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

package alv_pkg;

    // Segments per arc; must be a power of two in 1..32
    localparam int STEPS      = 32;
    localparam int STEPS_LOG2 = $clog2(STEPS);
    localparam int IDX_W      = $clog2(STEPS + 1);
    localparam int CNT_W      = $clog2(2 * STEPS);

    // Arc queue depth
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Registers between the angle and the scaled trig value
    localparam int TRIG_LAT = 6;

    // Binary angle quarter turn
    localparam logic [15:0] QUARTER   = 16'h4000;
    localparam logic [14:0] QUARTER_Z = 15'h4000;

    // Quarter-wave sine polynomial coefficients
    localparam logic [15:0] COEF_A = 16'd51472;
    localparam logic [14:0] COEF_B = 15'd21024;
    localparam logic [11:0] COEF_C = 12'd2320;

    // Rounding offset for Q15 * Q8.8 -> Q8.8
    localparam logic signed [33:0] ROUND_HALF = 34'sd16384;

    // Classified arc as it waits in the queue
    typedef struct packed {
        logic signed [15:0] cx;
        logic signed [15:0] cy;
        logic [14:0]        radius;
        logic [15:0]        start_ang;
        logic [15:0]        sweep;
    } t_arc;

endpackage

`default_nettype wire

// ----- hw/rtl/alv_front.sv -----
// ----------------------------------------------------------------------------
// alv_front: arc intake
// Captures one arc per transaction, folds the end angle into a sweep and
// hands the descriptor to the arc queue.
// ----------------------------------------------------------------------------
`default_nettype none

module alv_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    output logic                    o_busy,
    input  wire logic signed [15:0] i_center_x,
    input  wire logic signed [15:0] i_center_y,
    input  wire logic [14:0]        i_radius,
    input  wire logic [15:0]        i_start_angle,
    input  wire logic [15:0]        i_end_angle,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output alv_pkg::t_arc           o_arc
);

    logic          r_valid;
    alv_pkg::t_arc r_arc;
    logic          accept;

    // Drain into the queue whenever it has room
    assign o_push = r_valid && !i_q_full;
    assign o_busy = r_valid && i_q_full;
    assign accept = i_start && !o_busy;
    assign o_arc  = r_arc;

    // Hold the pending descriptor until the queue takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // Sweep wraps modulo one turn, so an end below the start adds a turn
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_arc.cx        <= i_center_x;
            r_arc.cy        <= i_center_y;
            r_arc.radius    <= i_radius;
            r_arc.start_ang <= i_start_angle;
            r_arc.sweep     <= 16'(i_end_angle - i_start_angle);
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/alv_queue.sv -----
// ----------------------------------------------------------------------------
// alv_queue: arc descriptor queue
// Short FIFO between intake and vertex generation.
// ----------------------------------------------------------------------------
`default_nettype none

module alv_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire alv_pkg::t_arc i_arc,
    input  wire logic          i_pop,
    output alv_pkg::t_arc      o_arc,
    output logic               o_valid,
    output logic               o_full
);

    alv_pkg::t_arc                     r_mem [alv_pkg::Q_DEPTH];
    logic [alv_pkg::Q_PTR_W-1:0]       r_wr_ptr;
    logic [alv_pkg::Q_PTR_W-1:0]       r_rd_ptr;
    logic [alv_pkg::Q_CNT_W-1:0]       r_count;
    logic [alv_pkg::Q_CNT_W-1:0]       n_count;

    localparam logic [alv_pkg::Q_CNT_W-1:0] FULL_CNT = alv_pkg::Q_CNT_W'(alv_pkg::Q_DEPTH);
    localparam logic [alv_pkg::Q_PTR_W-1:0] LAST_PTR =
        alv_pkg::Q_PTR_W'(alv_pkg::Q_DEPTH - 1);

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_arc   = r_mem[r_rd_ptr];

    // Track occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_arc;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("arc queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("arc queue read while empty");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("arc queue count lost a write");

endmodule

`default_nettype wire

// ----- hw/rtl/alv_trig.sv -----
// ----------------------------------------------------------------------------
// alv_trig: pipelined fixed-point sine and radius scaling
// Quarter-wave polynomial sine in Q15, then round(sin * radius) in Q8.8.
// One angle per cycle, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

module alv_trig (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_angle,
    input  wire logic [14:0] i_radius,
    output logic signed [18:0] o_scaled
);

    localparam logic [14:0] QUARTER_Z_LOCAL = alv_pkg::QUARTER_Z;

    logic [13:0] frac;
    logic [14:0] z;

    // Stage 1: fold into the first quadrant
    logic [15:0] r1_z15;
    logic        r1_neg;
    logic [14:0] r1_rad;
    // Stage 2: z squared
    logic [15:0] r2_z15;
    logic [15:0] r2_z2;
    logic        r2_neg;
    logic [14:0] r2_rad;
    // Stage 3: inner term
    logic [15:0] r3_z15;
    logic [15:0] r3_z2;
    logic [14:0] r3_inner;
    logic        r3_neg;
    logic [14:0] r3_rad;
    // Stage 4: middle term
    logic [15:0] r4_z15;
    logic [15:0] r4_mid;
    logic        r4_neg;
    logic [14:0] r4_rad;
    // Stage 5: signed sine
    logic signed [17:0] r5_trig;
    logic [14:0]        r5_rad;

    logic [31:0] sq;
    logic [27:0] c_prod;
    logic [30:0] b_prod;
    logic [31:0] a_prod;
    logic [16:0] s_mag;
    logic signed [33:0] scale_prod;

    assign frac = i_angle[13:0];
    assign z    = i_angle[14] ? 15'(QUARTER_Z_LOCAL - {1'b0, frac}) : {1'b0, frac};

    assign sq         = 32'(r1_z15) * 32'(r1_z15);
    assign c_prod     = 28'(r2_z2) * 28'(alv_pkg::COEF_C);
    assign b_prod     = 31'(r3_z2) * 31'(r3_inner);
    assign a_prod     = 32'(r4_z15) * 32'(r4_mid);
    assign s_mag      = a_prod[31:15];
    assign scale_prod = 34'(r5_trig) * 34'($signed({1'b0, r5_rad})) + alv_pkg::ROUND_HALF;

    always_ff @(posedge i_clk) begin
        // fold
        r1_z15 <= {z, 1'b0};
        r1_neg <= i_angle[15];
        r1_rad <= i_radius;
        // square
        r2_z15 <= r1_z15;
        r2_z2  <= sq[30:15];
        r2_neg <= r1_neg;
        r2_rad <= r1_rad;
        // inner = B - z2*C
        r3_z15   <= r2_z15;
        r3_z2    <= r2_z2;
        r3_inner <= alv_pkg::COEF_B - 15'(c_prod[27:15]);
        r3_neg   <= r2_neg;
        r3_rad   <= r2_rad;
        // mid = A - z2*inner
        r4_z15 <= r3_z15;
        r4_mid <= alv_pkg::COEF_A - b_prod[30:15];
        r4_neg <= r3_neg;
        r4_rad <= r3_rad;
        // apply the sign of the lower half turn
        r5_trig <= r4_neg ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        r5_rad  <= r4_rad;
        // round half up, floor shift
        o_scaled <= 19'(scale_prod >>> 15);
    end

endmodule

`default_nettype wire

// ----- hw/rtl/alv_back.sv -----
// ----------------------------------------------------------------------------
// alv_back: vertex generator
// Walks one queued arc over 2*STEPS vertex slots, one per cycle, runs the
// sine and cosine pipelines and emits saturated vertex coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

module alv_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire alv_pkg::t_arc i_arc,
    input  wire logic          i_q_valid,
    output logic               o_pop,
    output logic               o_valid,
    output logic signed [15:0] o_vert_x,
    output logic signed [15:0] o_vert_y,
    output logic               o_is_last
);

    localparam int IW = alv_pkg::IDX_W;
    localparam int CW = alv_pkg::CNT_W;
    localparam int LAT = alv_pkg::TRIG_LAT;
    localparam logic [CW-1:0] LAST_CNT = CW'(2 * alv_pkg::STEPS - 1);

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] res;
        if (v > 20'sd32767) begin
            res = 16'sh7fff;
        end else if (v < -20'sd32768) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Sequencer
    alv_pkg::t_arc r_arc;
    logic          r_active;
    logic [CW-1:0] r_cnt;
    logic          at_end;

    // Angle stage
    logic               r_a_valid;
    logic               r_a_last;
    logic [15:0]        r_a_ang;
    logic [14:0]        r_a_rad;
    logic signed [15:0] r_a_cx;
    logic signed [15:0] r_a_cy;

    // Side line that travels with the trig pipelines
    logic               r_sl_valid [LAT];
    logic               r_sl_last  [LAT];
    logic signed [15:0] r_sl_cx    [LAT];
    logic signed [15:0] r_sl_cy    [LAT];

    logic [CW:0]        cnt_inc;
    logic [IW-1:0]      pt_idx;
    logic [15+IW:0]     step_prod;
    logic [15+IW:0]     step_off;
    logic [15:0]        cos_ang;
    logic signed [18:0] cos_scaled;
    logic signed [18:0] sin_scaled;

    assign at_end = (r_cnt == LAST_CNT);
    assign o_pop  = i_q_valid && (!r_active || at_end);

    // Vertex slot n shows point (n+1)/2: interior points come twice
    assign cnt_inc   = {1'b0, r_cnt} + 1'b1;
    assign pt_idx    = IW'(cnt_inc >> 1);
    assign step_prod = (16 + IW)'(r_arc.sweep) * (16 + IW)'(pt_idx);
    assign step_off  = step_prod >> alv_pkg::STEPS_LOG2;

    // Load the next arc when idle or on the last slot of the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else if (o_pop) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else if (r_active) begin
            if (at_end) begin
                r_active <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_arc <= i_arc;
        end
    end

    // Compute the point angle for this slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_last <= at_end;
        r_a_ang  <= 16'(r_arc.start_ang + step_off[15:0]);
        r_a_rad  <= r_arc.radius;
        r_a_cx   <= r_arc.cx;
        r_a_cy   <= r_arc.cy;
    end

    assign cos_ang = 16'(r_a_ang + alv_pkg::QUARTER);

    alv_trig u_cos (
        .i_clk    (i_clk),
        .i_angle  (cos_ang),
        .i_radius (r_a_rad),
        .o_scaled (cos_scaled)
    );

    alv_trig u_sin (
        .i_clk    (i_clk),
        .i_angle  (r_a_ang),
        .i_radius (r_a_rad),
        .o_scaled (sin_scaled)
    );

    // Carry center and flags alongside the trig latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_sl_valid[k] <= 1'b0;
            end
        end else begin
            r_sl_valid[0] <= r_a_valid;
            for (int k = 1; k < LAT; k++) begin
                r_sl_valid[k] <= r_sl_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sl_last[0] <= r_a_last;
        r_sl_cx[0]   <= r_a_cx;
        r_sl_cy[0]   <= r_a_cy;
        for (int k = 1; k < LAT; k++) begin
            r_sl_last[k] <= r_sl_last[k-1];
            r_sl_cx[k]   <= r_sl_cx[k-1];
            r_sl_cy[k]   <= r_sl_cy[k-1];
        end
    end

    // Offset from the center and saturate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_sl_valid[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        o_is_last <= r_sl_valid[LAT-1] && r_sl_last[LAT-1];
        o_vert_x  <= sat16(20'(r_sl_cx[LAT-1]) + 20'(cos_scaled));
        o_vert_y  <= sat16(20'(r_sl_cy[LAT-1]) + 20'(sin_scaled));
    end

    a_arc_runs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active && !at_end) |=> (r_active && r_cnt == $past(r_cnt) + 1'b1))
        else $error("arc walk stopped before its last slot");

    a_last_spaced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_last) |=> !o_is_last)
        else $error("two final vertices in a row");

    a_last_marks_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_is_last |-> o_valid)
        else $error("final vertex flag without a vertex");

endmodule

`default_nettype wire

// ----- hw/rtl/arc_to_line_vertices.sv -----
// ----------------------------------------------------------------------------
// arc_to_line_vertices: circular arc to line-list vertex stream
// Each arc becomes 2*STEPS vertices: start once, interior points twice,
// end once, with the final vertex flagged. Q8.8 coordinates, saturated.
//
//   channel   direction  handshake             payload
//   arc in    input      start & !busy         i_center_x/y, i_radius,
//                                              i_start_angle, i_end_angle
//   vertex    output     o_valid, one cycle    o_vert_x, o_vert_y, o_is_last
//
// One vertex per cycle while an arc is in the vertex generator; the slot
// counter walks each arc over 2*STEPS (64) slots.
// With the generator idle, the first vertex of an arc follows the intake
// register, arc queue, angle stage, trig pipelines and output registers.
// busy rises only when the intake register and the two-entry arc queue are
// all occupied; the vertex output has no stall.
// Reset is synchronous and clears intake, queue and pipeline valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_to_line_vertices (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] i_center_x,
    input  wire logic signed [15:0] i_center_y,
    input  wire logic [14:0]        i_radius,
    input  wire logic [15:0]        i_start_angle,
    input  wire logic [15:0]        i_end_angle,
    output logic                    o_valid,
    output logic signed [15:0]      o_vert_x,
    output logic signed [15:0]      o_vert_y,
    output logic                    o_is_last
);

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    alv_pkg::t_arc front_arc;
    alv_pkg::t_arc head_arc;

    alv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius      (i_radius),
        .i_start_angle (i_start_angle),
        .i_end_angle   (i_end_angle),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_arc         (front_arc)
    );

    alv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_arc   (front_arc),
        .i_pop   (pop),
        .o_arc   (head_arc),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    alv_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_arc     (head_arc),
        .i_q_valid (q_valid),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .o_vert_x  (o_vert_x),
        .o_vert_y  (o_vert_y),
        .o_is_last (o_is_last)
    );

endmodule

`default_nettype wire
